// File: design/ldcg_pkg.sv
`default_nettype none

package ldcg_pkg;

  localparam int unsigned MvWidth      = 16;
  localparam int unsigned ResWidth     = 24;
  localparam int unsigned PctWidth     = 7;
  localparam int unsigned CfgIdxWidth  = 8;
  localparam int unsigned NumWidth     = MvWidth + ResWidth + 1;

  localparam logic [CfgIdxWidth-1:0] CfgUpperIdx = 8'd0;
  localparam logic [CfgIdxWidth-1:0] CfgLowerIdx = 8'd1;

  localparam logic [ResWidth-1:0] UpperReset = 24'd100000;
  localparam logic [ResWidth-1:0] LowerReset = 24'd100000;

  localparam int unsigned CurvePoints    = 11;
  localparam int unsigned SegWidth       = 4;
  localparam int unsigned OffWidth       = 9;
  localparam int unsigned RiseWidth      = 5;
  localparam int unsigned InterpNumWidth = 14;
  localparam int unsigned InterpDenWidth = 10;
  localparam int unsigned QuoWidth       = 5;

  localparam logic [MvWidth-1:0] CurveMv [CurvePoints] = '{
    16'd3000, 16'd3300, 16'd3500, 16'd3600, 16'd3700, 16'd3750,
    16'd3800, 16'd3900, 16'd4000, 16'd4100, 16'd4200
  };

  localparam logic [PctWidth-1:0] CurvePct [CurvePoints] = '{
    7'd0, 7'd5, 7'd10, 7'd20, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90, 7'd100
  };

  // partial remainder plus a shift word: numerator bits out the top, quotient bits in the bottom
  typedef struct packed {
    logic [ResWidth-1:0] rem;
    logic [MvWidth-1:0]  word;
    logic                sat;
  } div_word_t;

endpackage

`default_nettype wire

// File: design/lipo_divider_charge_gauge.sv
`default_nettype none

// Turns a divider-tap reading (mV) into battery millivolts, floor(tap*(upper+lower)/lower)
// saturated at 65535 (0 when the lower resistor is 0), and a single-cell LiPo charge
// percent from an 11-point curve, 3000 mV = 0 % to 4200 mV = 100 %, rounded half up.
// Fully pipelined: one word per clock while out_stall_i is low, through front stages A and B,
// the one-bit-per-stage divider by the lower resistor, and stages C and D. Bubbles are
// squeezed out under output stall. Write the resistor registers only while idle.

module lipo_divider_charge_gauge import ldcg_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [ResWidth-1:0]    cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [MvWidth-1:0]     tap_millivolts_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [MvWidth-1:0]          battery_millivolts_o,
  output logic [PctWidth-1:0]         charge_percent_o
);

  logic [ResWidth-1:0] upper_q, lower_q;
  logic                front_ready;

  logic      stg_valid [MvWidth+1];
  logic      stg_ready [MvWidth+1];
  div_word_t stg_word  [MvWidth+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= UpperReset;
      lower_q <= LowerReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgUpperIdx: upper_q <= cfg_data_i;
        CfgLowerIdx: lower_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = !front_ready;

  ldcg_scale_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upper_i     (upper_q),
    .lower_i     (lower_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (front_ready),
    .tap_i       (tap_millivolts_i),
    .out_valid_o (stg_valid[0]),
    .out_ready_i (stg_ready[0]),
    .out_word_o  (stg_word[0])
  );

  for (genvar g = 0; g < MvWidth; g++) begin : g_div
    ldcg_div_stage u_div (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .lower_i     (lower_q),
      .in_valid_i  (stg_valid[g]),
      .in_ready_o  (stg_ready[g]),
      .in_word_i   (stg_word[g]),
      .out_valid_o (stg_valid[g+1]),
      .out_ready_i (stg_ready[g+1]),
      .out_word_o  (stg_word[g+1])
    );
  end

  ldcg_soc_interp u_interp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lower_i     (lower_q),
    .in_valid_i  (stg_valid[MvWidth]),
    .in_ready_o  (stg_ready[MvWidth]),
    .in_word_i   (stg_word[MvWidth]),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .mv_o        (battery_millivolts_o),
    .pct_o       (charge_percent_o)
  );

endmodule

`default_nettype wire

// File: design/ldcg_scale_front.sv
`default_nettype none

module ldcg_scale_front import ldcg_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [ResWidth-1:0] upper_i,
  input  wire logic [ResWidth-1:0] lower_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [MvWidth-1:0]  tap_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output div_word_t                out_word_o
);

  logic                ready_b;
  logic                valid_a_q;
  logic [NumWidth-1:0] num_a_d, num_a_q;
  logic                valid_b_q;
  div_word_t           word_b_d, word_b_q;

  assign ready_b    = !valid_b_q || out_ready_i;
  assign in_ready_o = !valid_a_q || ready_b;

  // stage A: tap * (upper + lower)
  assign num_a_d = NumWidth'(tap_i) * NumWidth'({1'b0, upper_i} + {1'b0, lower_i});

  // stage B: saturation test and divider seed
  always_comb begin
    word_b_d.sat  = num_a_q[NumWidth-1:MvWidth] >= {1'b0, lower_i};
    word_b_d.rem  = num_a_q[NumWidth-2:MvWidth];
    word_b_d.word = num_a_q[MvWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        valid_a_q <= in_valid_i;
      end
      if (ready_b) begin
        valid_b_q <= valid_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      num_a_q <= num_a_d;
    end
    if (ready_b) begin
      word_b_q <= word_b_d;
    end
  end

  assign out_valid_o = valid_b_q;
  assign out_word_o  = word_b_q;

endmodule

`default_nettype wire

// File: design/ldcg_div_stage.sv
`default_nettype none

module ldcg_div_stage import ldcg_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [ResWidth-1:0] lower_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire div_word_t           in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output div_word_t                out_word_o
);

  logic [ResWidth:0] trial;
  logic              fits;
  logic              valid_q;
  div_word_t         word_d, word_q;

  assign in_ready_o = !valid_q || out_ready_i;

  // one restoring step: bring down one numerator bit, subtract if it fits
  always_comb begin
    trial       = {in_word_i.rem, in_word_i.word[MvWidth-1]};
    fits        = trial >= {1'b0, lower_i};
    word_d.sat  = in_word_i.sat;
    word_d.rem  = fits ? ResWidth'(trial - {1'b0, lower_i}) : trial[ResWidth-1:0];
    word_d.word = {in_word_i.word[MvWidth-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

`default_nettype wire

// File: design/ldcg_soc_interp.sv
`default_nettype none

module ldcg_soc_interp import ldcg_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [ResWidth-1:0] lower_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire div_word_t           in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [MvWidth-1:0]       mv_o,
  output logic [PctWidth-1:0]      pct_o
);

  logic                      ready_d;
  logic                      valid_c_q, valid_d_q;

  logic [MvWidth-1:0]        mv_c;
  logic                      low_c, high_c;
  logic [SegWidth-1:0]       seg, seg_nx;
  logic [OffWidth-1:0]       span, off;
  logic [RiseWidth-1:0]      rise;
  logic [InterpNumWidth:0]   prod;
  logic [InterpNumWidth-1:0] num_c_d, num_c_q;
  logic [InterpDenWidth-1:0] den_c_d, den_c_q;
  logic [PctWidth-1:0]       base_c_d, base_c_q;
  logic [MvWidth-1:0]        mv_c_q;

  logic [InterpNumWidth-1:0] rem, dsh;
  logic [QuoWidth-1:0]       quo;
  logic [PctWidth-1:0]       pct_d, pct_q;
  logic [MvWidth-1:0]        mv_q;

  assign ready_d    = !valid_d_q || out_ready_i;
  assign in_ready_o = !valid_c_q || ready_d;

  // stage C: battery voltage, segment pick, interpolation numerator
  always_comb begin
    if (lower_i == '0) begin
      mv_c = '0;
    end else if (in_word_i.sat) begin
      mv_c = '1;
    end else begin
      mv_c = in_word_i.word;
    end
    low_c  = mv_c <= CurveMv[0];
    high_c = mv_c >= CurveMv[CurvePoints-1];
    seg    = '0;
    for (int j = 1; j < CurvePoints - 1; j++) begin
      if (mv_c > CurveMv[j]) begin
        seg = SegWidth'(j);
      end
    end
    seg_nx  = seg + SegWidth'(1);
    span    = OffWidth'(CurveMv[seg_nx] - CurveMv[seg]);
    rise    = RiseWidth'(CurvePct[seg_nx] - CurvePct[seg]);
    off     = OffWidth'(mv_c - CurveMv[seg]);
    prod    = (InterpNumWidth + 1)'(rise) * (InterpNumWidth + 1)'(off);
    num_c_d = InterpNumWidth'((prod << 1) + (InterpNumWidth + 1)'(span));
    den_c_d = {span, 1'b0};
    if (low_c) begin
      base_c_d = CurvePct[0];
      num_c_d  = '0;
    end else if (high_c) begin
      base_c_d = CurvePct[CurvePoints-1];
      num_c_d  = '0;
    end else begin
      base_c_d = CurvePct[seg];
    end
  end

  // stage D: short restoring divide, rounds half up via the span bias
  always_comb begin
    rem = num_c_q;
    quo = '0;
    dsh = '0;
    for (int i = QuoWidth - 1; i >= 0; i--) begin
      dsh = InterpNumWidth'(den_c_q) << i;
      if (rem >= dsh) begin
        rem    = rem - dsh;
        quo[i] = 1'b1;
      end
    end
    pct_d = base_c_q + PctWidth'(quo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_c_q <= 1'b0;
      valid_d_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        valid_c_q <= in_valid_i;
      end
      if (ready_d) begin
        valid_d_q <= valid_c_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      mv_c_q   <= mv_c;
      num_c_q  <= num_c_d;
      den_c_q  <= den_c_d;
      base_c_q <= base_c_d;
    end
    if (ready_d) begin
      mv_q  <= mv_c_q;
      pct_q <= pct_d;
    end
  end

  assign out_valid_o = valid_d_q;
  assign mv_o        = mv_q;
  assign pct_o       = pct_q;

endmodule

`default_nettype wire
